// ----- sv/fxa_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and codes for the Q24.8 fixed-point ALU.
// No dependencies.
package fxa_pkg;

  localparam logic [3:0] OP_ADD      = 4'd0;
  localparam logic [3:0] OP_SUB      = 4'd1;
  localparam logic [3:0] OP_MUL      = 4'd2;
  localparam logic [3:0] OP_DIV      = 4'd3;
  localparam logic [3:0] OP_GT       = 4'd4;
  localparam logic [3:0] OP_LT       = 4'd5;
  localparam logic [3:0] OP_GE       = 4'd6;
  localparam logic [3:0] OP_LE       = 4'd7;
  localparam logic [3:0] OP_EQ       = 4'd8;
  localparam logic [3:0] OP_NE       = 4'd9;
  localparam logic [3:0] OP_INC      = 4'd10;
  localparam logic [3:0] OP_DEC      = 4'd11;
  localparam logic [3:0] OP_TO_INT   = 4'd12;
  localparam logic [3:0] OP_FROM_INT = 4'd13;

  // Work class of a queued transaction
  localparam logic [1:0] KIND_SIMPLE = 2'd0;
  localparam logic [1:0] KIND_MUL    = 2'd1;
  localparam logic [1:0] KIND_DIV    = 2'd2;

  typedef struct packed {
    logic [1:0]         kind;
    logic [31:0]        word;
    logic               cmp;
    logic               dz;
    logic signed [31:0] a;
    logic signed [31:0] b;
  } item_t;

endpackage

// ----- sv/fxa_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the fixed-point ALU.
// No dependencies.
interface fxa_req_if;
  logic               valid;
  logic               ready;
  logic [3:0]         opcode;
  logic signed [31:0] operand_a;
  logic signed [31:0] operand_b;
  modport source (output valid, opcode, operand_a, operand_b, input ready);
  modport sink (input valid, opcode, operand_a, operand_b, output ready);
endinterface

interface fxa_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_word;
  logic               compare_true;
  logic               divide_by_zero;
  modport source (output valid, result_word, compare_true, divide_by_zero, input ready);
  modport sink (input valid, result_word, compare_true, divide_by_zero, output ready);
endinterface

// ----- sv/fixed_point_q24_8_alu.sv -----
`timescale 1ns / 1ps
// Top level of the signed fixed-point ALU (Q24.8 by default).
// Depends on fxa_pkg, fxa_if, fxa_front, fxa_queue and fxa_back.

// Signed 32-bit fixed-point ALU with FRAC_BITS fraction bits. Each req
// transaction carries an opcode and two raw operands and yields exactly one
// rsp transaction, in order. Throughput is one transaction per cycle for every
// opcode when rsp does not stall; each passes the queue, the restoring divider
// pipe (which retires one quotient bit per stage and which all opcodes pass
// through to keep order) and the output register.
// The front end settles add, subtract, compares, inc/dec and conversions in
// the accepting cycle and parks transactions in a QUEUE_DEPTH-entry FIFO, so
// req stays ready for up to QUEUE_DEPTH transactions while the back end is
// held by rsp backpressure. The whole back pipe advances whenever the output
// register is empty or being taken.
// Multiply keeps the 64-bit product shifted right arithmetically; divide
// truncates toward zero, and a zero divisor returns 0 with divide_by_zero set.
// Results wrap modulo 2^32. Opcodes 14 and 15 return all zeros.
module fixed_point_q24_8_alu #(
  parameter int FRAC_BITS   = 8,
  parameter int QUEUE_DEPTH = 4
) (
  input logic       clk,
  input logic       rst,
  fxa_req_if.sink   req,
  fxa_rsp_if.source rsp
);

  logic           push;
  logic           pop;
  logic           full;
  logic           not_empty;
  fxa_pkg::item_t push_item;
  fxa_pkg::item_t head;

  // classify and settle the simple ops
  fxa_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .req       (req),
    .full      (full),
    .push      (push),
    .push_item (push_item)
  );

  // decouples acceptance from back-end stalls
  fxa_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .full      (full),
    .not_empty (not_empty),
    .head      (head)
  );

  // multiply, divide and the output register
  fxa_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (not_empty),
    .head       (head),
    .pop        (pop),
    .rsp        (rsp)
  );

endmodule

// ----- sv/fxa_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts requests, classifies them and settles the simple ops combinationally.
// Depends on fxa_pkg and fxa_req_if.
module fxa_front #(
  parameter int FRAC_BITS = 8
) (
  fxa_req_if.sink       req,
  input  logic          full,
  output logic          push,
  output fxa_pkg::item_t push_item
);

  logic signed [31:0] a;
  logic signed [31:0] b;
  logic signed [31:0] bias;

  assign a = req.operand_a;
  assign b = req.operand_b;
  assign req.ready = !full;
  assign push = req.valid && !full;
  // truncation toward zero for negative values
  assign bias = a[31] ? 32'sd1 <<< FRAC_BITS : 32'sd1;

  always_comb begin
    push_item      = '0;
    push_item.a    = a;
    push_item.b    = b;
    push_item.kind = fxa_pkg::KIND_SIMPLE;
    case (req.opcode)
      fxa_pkg::OP_ADD:      push_item.word = a + b;
      fxa_pkg::OP_SUB:      push_item.word = a - b;
      fxa_pkg::OP_MUL:      push_item.kind = fxa_pkg::KIND_MUL;
      fxa_pkg::OP_DIV: begin
        push_item.kind = fxa_pkg::KIND_DIV;
        push_item.dz   = (b == 32'sd0);
      end
      fxa_pkg::OP_GT:       push_item.cmp = a > b;
      fxa_pkg::OP_LT:       push_item.cmp = a < b;
      fxa_pkg::OP_GE:       push_item.cmp = a >= b;
      fxa_pkg::OP_LE:       push_item.cmp = a <= b;
      fxa_pkg::OP_EQ:       push_item.cmp = a == b;
      fxa_pkg::OP_NE:       push_item.cmp = a != b;
      fxa_pkg::OP_INC:      push_item.word = a + 32'sd1;
      fxa_pkg::OP_DEC:      push_item.word = a - 32'sd1;
      fxa_pkg::OP_TO_INT:   push_item.word = (a + bias - 32'sd1) >>> FRAC_BITS;
      fxa_pkg::OP_FROM_INT: push_item.word = a <<< FRAC_BITS;
      default:              push_item.word = '0;
    endcase
  end

endmodule

// ----- sv/fxa_queue.sv -----
`timescale 1ns / 1ps
// Small FIFO between front and back end, head visible without a read cycle.
// Depends on fxa_pkg.
module fxa_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  fxa_pkg::item_t push_item,
  input  logic           pop,
  output logic           full,
  output logic           not_empty,
  output fxa_pkg::item_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  fxa_pkg::item_t slots [0:DEPTH-1];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- sv/fxa_back.sv -----
`timescale 1ns / 1ps
// Back end: multiplier stage and a one-bit-per-stage restoring divider pipe.
// Depends on fxa_pkg and fxa_rsp_if.
module fxa_back #(
  parameter int FRAC_BITS = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  input  fxa_pkg::item_t head,
  output logic           pop,
  fxa_rsp_if.source      rsp
);

  localparam int DW = 32 + FRAC_BITS;  // dividend bits, one stage each

  logic              adv;
  logic              sv   [0:DW];
  logic [1:0]        kind [0:DW];
  logic [31:0]       word [0:DW];
  logic              cmp  [0:DW];
  logic              dz   [0:DW];
  logic              neg  [0:DW];
  logic [31:0]       rem  [0:DW];
  logic [DW-1:0]     quo  [0:DW];
  logic [31:0]       dvs  [0:DW];
  logic signed [63:0] prod;
  logic [31:0]       a_mag;
  logic [31:0]       b_mag;
  logic [31:0]       q_low;

  assign adv = !rsp.valid || rsp.ready;
  assign pop = adv && head_valid;
  assign a_mag = head.a[31] ? 32'(-head.a) : 32'(head.a);
  assign b_mag = head.b[31] ? 32'(-head.b) : 32'(head.b);

  always_ff @(posedge clk) begin
    if (rst) begin
      sv[0] <= 1'b0;
    end else if (adv) begin
      sv[0] <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      kind[0] <= head.kind;
      word[0] <= head.word;
      cmp[0]  <= head.cmp;
      dz[0]   <= head.dz;
      neg[0]  <= head.a[31] ^ head.b[31];
      rem[0]  <= '0;
      quo[0]  <= {a_mag, {FRAC_BITS{1'b0}}};
      dvs[0]  <= b_mag;
      prod    <= head.a * head.b;
    end
  end

  for (genvar i = 1; i <= DW; i++) begin : g_stage
    logic [32:0] trial;
    logic        fits;
    assign trial = {rem[i-1], quo[i-1][DW-1]};
    assign fits  = trial >= {1'b0, dvs[i-1]};

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[i] <= 1'b0;
      end else if (adv) begin
        sv[i] <= sv[i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        kind[i] <= kind[i-1];
        cmp[i]  <= cmp[i-1];
        dz[i]   <= dz[i-1];
        neg[i]  <= neg[i-1];
        dvs[i]  <= dvs[i-1];
        rem[i]  <= fits ? 32'(trial - {1'b0, dvs[i-1]}) : trial[31:0];
        quo[i]  <= {quo[i-1][DW-2:0], fits};
        if (i == 1 && kind[0] == fxa_pkg::KIND_MUL) begin
          word[i] <= prod[FRAC_BITS+31:FRAC_BITS];
        end else begin
          word[i] <= word[i-1];
        end
      end
    end
  end

  assign q_low = quo[DW][31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (adv) begin
      rsp.valid <= sv[DW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rsp.compare_true   <= cmp[DW];
      rsp.divide_by_zero <= dz[DW];
      if (kind[DW] == fxa_pkg::KIND_DIV) begin
        rsp.result_word <= dz[DW] ? 32'sd0 : (neg[DW] ? $signed(-q_low) : $signed(q_low));
      end else begin
        rsp.result_word <= $signed(word[DW]);
      end
    end
  end

endmodule
